>>> rtl/sev_pkg.sv
// Package for the string escape validator: scan phase type, character codes,
// stream field layout and byte classifiers. No dependencies.
package sev_pkg;

    localparam int BYTE_W    = 8;
    localparam int FIELD_W   = 24;
    localparam int S_DATA_W  = 56;
    localparam int M_DATA_W  = 56;

    // Input tdata layout
    localparam int S_BYTE_LSB = 0;
    localparam int S_LINE_LSB = 8;
    localparam int S_COL_LSB  = 32;

    // Output tdata layout
    localparam int M_VALID_BIT = 0;
    localparam int M_LINE_LSB  = 1;
    localparam int M_COL_LSB   = 25;
    localparam int M_USED_W    = 49;

    typedef enum logic [2:0] {
        PH_TEXT      = 3'd0,
        PH_ESCAPE    = 3'd1,
        PH_U         = 3'd2,
        PH_HEX_FIRST = 3'd3,
        PH_HEX_MORE  = 3'd4,
        PH_INTERP    = 3'd5,
        PH_FAILED    = 3'd6
    } t_phase;

    localparam logic [7:0] CH_N         = 8'h6E;
    localparam logic [7:0] CH_T         = 8'h74;
    localparam logic [7:0] CH_R         = 8'h72;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_DQUOTE    = 8'h22;
    localparam logic [7:0] CH_SQUOTE    = 8'h27;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_LPAREN    = 8'h28;
    localparam logic [7:0] CH_RPAREN    = 8'h29;
    localparam logic [7:0] CH_U         = 8'h75;
    localparam logic [7:0] CH_LBRACE    = 8'h7B;
    localparam logic [7:0] CH_RBRACE    = 8'h7D;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;

    function automatic logic is_hex(input logic [7:0] b);
        is_hex = (b >= 8'h30 && b <= 8'h39) || (b >= 8'h61 && b <= 8'h66) ||
                 (b >= 8'h41 && b <= 8'h46);
    endfunction

    function automatic logic is_plain_escape(input logic [7:0] b);
        is_plain_escape = (b == CH_N) || (b == CH_T) || (b == CH_R) || (b == CH_ZERO) ||
                          (b == CH_DQUOTE) || (b == CH_SQUOTE) || (b == CH_BACKSLASH);
    endfunction

endpackage

>>> rtl/string_escape_validator.sv
// String-literal escape validator, top level.
// Depends on sev_pkg.
//
// Usage:
//   s_axis carries one body byte per transfer. tuser marks the first byte of a
//   body (its start line and column are loaded from tdata), tlast the final one.
//   m_axis carries one result per body, sent after the transfer with tlast.
//   The result says whether every backslash escape was valid and, if not, the
//   line and column of the first bad backslash (zero when valid).
// Timing:
//   One byte per cycle while s_axis_tready is high. Each byte updates the scan state;
//   the result is registered into the output stage and then offered on m_axis.
//   A two-entry output stage (result register plus skid register) lets bytes
//   keep flowing while a result waits; s_axis_tready drops only when both
//   entries hold results, and rises again once the receiver takes one.
// Reset:
//   i_rst_n (synchronous, active low) clears the scan state, the position
//   counters and both output entries.
module string_escape_validator #(
    parameter int POSITION_BITS = 24,
    parameter int NEST_BITS     = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [7:0] body_byte, [31:8] origin_line, [55:32] start_column
    input  logic [sev_pkg::S_DATA_W-1:0]  s_axis_tdata,
    // [0] first_byte
    input  logic [0:0]                    s_axis_tuser,
    input  logic                          s_axis_tlast,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [0] escapes_valid, [24:1] error_line, [48:25] error_column, [55:49] zero
    output logic [sev_pkg::M_DATA_W-1:0]  m_axis_tdata
);

    localparam int PW = POSITION_BITS;
    localparam int NW = NEST_BITS;

    // Scan state
    sev_pkg::t_phase r_phase, n_phase;
    logic [NW-1:0]   r_depth, n_depth;
    logic [PW-1:0]   r_line, n_line;
    logic [PW-1:0]   r_col, n_col;
    logic [PW-1:0]   r_bs_col, n_bs_col;
    logic [PW-1:0]   r_fail_line, n_fail_line;
    logic [PW-1:0]   r_fail_col, n_fail_col;

    // Output stage
    logic                          r_out_valid, r_skid_valid;
    logic [sev_pkg::M_DATA_W-1:0]  r_out_data, r_skid_data;

    logic                          in_xfer, out_take, res_valid;
    logic [sev_pkg::M_DATA_W-1:0]  res_data;

    logic [7:0]      b;
    sev_pkg::t_phase ph0, ph1, ph_end;
    logic [NW-1:0]   dep0, dep1;
    logic [PW-1:0]   line0, col0, bs0, fl0, fc0;
    logic [PW-1:0]   line1, col1, bs1, fl1, fc1, fl_end, fc_end;

    assign s_axis_tready = !r_skid_valid;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_take      = r_out_valid && m_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    assign b = s_axis_tdata[sev_pkg::S_BYTE_LSB +: sev_pkg::BYTE_W];

    // First byte of a body restarts the scan at the supplied position
    always_comb begin
        if (s_axis_tuser[0]) begin
            ph0   = sev_pkg::PH_TEXT;
            dep0  = '0;
            line0 = PW'(s_axis_tdata[sev_pkg::S_LINE_LSB +: sev_pkg::FIELD_W]);
            col0  = PW'(s_axis_tdata[sev_pkg::S_COL_LSB +: sev_pkg::FIELD_W]);
            bs0   = '0;
            fl0   = '0;
            fc0   = '0;
        end else begin
            ph0   = r_phase;
            dep0  = r_depth;
            line0 = r_line;
            col0  = r_col;
            bs0   = r_bs_col;
            fl0   = r_fail_line;
            fc0   = r_fail_col;
        end
    end

    // Escape checking; a failure records the backslash position
    always_comb begin
        ph1  = ph0;
        dep1 = dep0;
        bs1  = bs0;
        fl1  = fl0;
        fc1  = fc0;
        case (ph0)
            sev_pkg::PH_ESCAPE: begin
                if (sev_pkg::is_plain_escape(b)) begin
                    ph1 = sev_pkg::PH_TEXT;
                end else if (b == sev_pkg::CH_LPAREN) begin
                    ph1  = sev_pkg::PH_INTERP;
                    dep1 = NW'(1);
                end else if (b == sev_pkg::CH_U) begin
                    ph1 = sev_pkg::PH_U;
                end else begin
                    ph1 = sev_pkg::PH_FAILED;
                    fl1 = line0;
                    fc1 = bs0;
                end
            end
            sev_pkg::PH_U: begin
                if (b == sev_pkg::CH_LBRACE) begin
                    ph1 = sev_pkg::PH_HEX_FIRST;
                end else begin
                    ph1 = sev_pkg::PH_FAILED;
                    fl1 = line0;
                    fc1 = bs0;
                end
            end
            sev_pkg::PH_HEX_FIRST: begin
                if (sev_pkg::is_hex(b)) begin
                    ph1 = sev_pkg::PH_HEX_MORE;
                end else begin
                    ph1 = sev_pkg::PH_FAILED;
                    fl1 = line0;
                    fc1 = bs0;
                end
            end
            sev_pkg::PH_HEX_MORE: begin
                if (b == sev_pkg::CH_RBRACE) begin
                    ph1 = sev_pkg::PH_TEXT;
                end else if (!sev_pkg::is_hex(b)) begin
                    ph1 = sev_pkg::PH_FAILED;
                    fl1 = line0;
                    fc1 = bs0;
                end
            end
            sev_pkg::PH_INTERP: begin
                if (b == sev_pkg::CH_LPAREN) begin
                    if (!(&dep0)) dep1 = dep0 + NW'(1);
                end else if (b == sev_pkg::CH_RPAREN) begin
                    if (dep0 != '0) dep1 = dep0 - NW'(1);
                end
                if (dep1 == '0) ph1 = sev_pkg::PH_TEXT;
            end
            sev_pkg::PH_FAILED: begin
                ph1 = sev_pkg::PH_FAILED;
            end
            default: begin
                ph1 = sev_pkg::PH_TEXT;
                if (b == sev_pkg::CH_BACKSLASH) begin
                    bs1 = col0;
                    ph1 = sev_pkg::PH_ESCAPE;
                end
            end
        endcase
    end

    // Position tracking, saturating
    always_comb begin
        line1 = line0;
        col1  = col0;
        if (b == sev_pkg::CH_NEWLINE) begin
            if (!(&line0)) line1 = line0 + PW'(1);
            col1 = PW'(1);
        end else if (!(&col0)) begin
            col1 = col0 + PW'(1);
        end
    end

    // End of body: an unfinished escape fails, then the result is formed
    always_comb begin
        ph_end = ph1;
        fl_end = fl1;
        fc_end = fc1;
        if (ph1 == sev_pkg::PH_ESCAPE || ph1 == sev_pkg::PH_U ||
            ph1 == sev_pkg::PH_HEX_FIRST || ph1 == sev_pkg::PH_HEX_MORE) begin
            ph_end = sev_pkg::PH_FAILED;
            fl_end = line1;
            fc_end = bs1;
        end
        res_valid = in_xfer && s_axis_tlast;
        res_data  = '0;
        if (ph_end == sev_pkg::PH_FAILED) begin
            res_data[sev_pkg::M_LINE_LSB +: sev_pkg::FIELD_W] = sev_pkg::FIELD_W'(fl_end);
            res_data[sev_pkg::M_COL_LSB +: sev_pkg::FIELD_W]  = sev_pkg::FIELD_W'(fc_end);
        end else begin
            res_data[sev_pkg::M_VALID_BIT] = 1'b1;
        end
    end

    always_comb begin
        n_line   = line1;
        n_col    = col1;
        n_bs_col = bs1;
        if (s_axis_tlast) begin
            n_phase     = sev_pkg::PH_TEXT;
            n_depth     = '0;
            n_fail_line = '0;
            n_fail_col  = '0;
        end else begin
            n_phase     = ph1;
            n_depth     = dep1;
            n_fail_line = fl1;
            n_fail_col  = fc1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= sev_pkg::PH_TEXT;
            r_depth     <= '0;
            r_line      <= '0;
            r_col       <= '0;
            r_bs_col    <= '0;
            r_fail_line <= '0;
            r_fail_col  <= '0;
        end else if (in_xfer) begin
            r_phase     <= n_phase;
            r_depth     <= n_depth;
            r_line      <= n_line;
            r_col       <= n_col;
            r_bs_col    <= n_bs_col;
            r_fail_line <= n_fail_line;
            r_fail_col  <= n_fail_col;
        end
    end

    // Output register with skid entry; skid fills only when the output is stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (!r_out_valid || out_take) begin
            r_out_valid <= res_valid;
        end else if (res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_take) r_out_data <= r_skid_data;
        end else if (!r_out_valid || out_take) begin
            if (res_valid) r_out_data <= res_data;
        end else if (res_valid) begin
            r_skid_data <= res_data;
        end
    end

endmodule

>>> rtl/sev_checker.sv
// Port-level checker for the string escape validator, bound to the top level.
// Depends on sev_pkg for the stream field layout.
module sev_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic [sev_pkg::S_DATA_W-1:0]  s_axis_tdata,
    input logic [0:0]                    s_axis_tuser,
    input logic                          s_axis_tlast,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [sev_pkg::M_DATA_W-1:0]  m_axis_tdata
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // A result only follows a transfer carrying tlast
    a_result_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready && s_axis_tlast))
        else $error("result without a final byte");

    // Input stalls only while a result is pending
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with output empty");

    // Passing result carries a zero position; padding stays zero
    a_result_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            (m_axis_tdata[sev_pkg::M_DATA_W-1:sev_pkg::M_USED_W] == '0) &&
            (!m_axis_tdata[sev_pkg::M_VALID_BIT] ||
             m_axis_tdata[sev_pkg::M_USED_W-1:sev_pkg::M_LINE_LSB] == '0))
        else $error("malformed result");

endmodule

bind string_escape_validator sev_checker u_sev_checker (.*);

>>> dv/escape_verdict_checker.sv
// Checker for the string escape validator: watches both stream channels, predicts the
// verdict for each body and compares it with what the block sends.
// Depends on sev_pkg.
module escape_verdict_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tvalid,
    input  logic                        i_s_tready,
    // [7:0] body_byte, [31:8] origin_line, [55:32] start_column
    input  logic [sev_pkg::S_DATA_W-1:0] i_s_tdata,
    // [0] first_byte
    input  logic [0:0]                  i_s_tuser,
    input  logic                        i_s_tlast,
    input  logic                        i_m_tvalid,
    input  logic                        i_m_tready,
    // [0] escapes_valid, [24:1] error_line, [48:25] error_column, [55:49] zero
    input  logic [sev_pkg::M_DATA_W-1:0] i_m_tdata,
    output int                          o_mismatches,
    output int                          o_outstanding,
    output int                          o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic                        ok;
        logic [sev_pkg::FIELD_W-1:0] line;
        logic [sev_pkg::FIELD_W-1:0] col;
    } t_verdict;

    localparam logic [sev_pkg::FIELD_W-1:0] POS_TOP   = '1;
    localparam logic [15:0]                 DEPTH_TOP = '1;

    sev_pkg::t_phase             scan_ph;
    logic [15:0]                 depth;
    logic [sev_pkg::FIELD_W-1:0] cur_line;
    logic [sev_pkg::FIELD_W-1:0] cur_col;
    logic [sev_pkg::FIELD_W-1:0] bs_col;
    logic [sev_pkg::FIELD_W-1:0] bad_line;
    logic [sev_pkg::FIELD_W-1:0] bad_col;
    t_verdict                    verdicts_due[$];
    int                          errs;
    int                          seen;

    function automatic logic hex_char(input logic [7:0] b);
        return (b >= "0" && b <= "9") || (b >= "a" && b <= "f") || (b >= "A" && b <= "F");
    endfunction

    function automatic logic simple_escape(input logic [7:0] b);
        case (b)
            sev_pkg::CH_N, sev_pkg::CH_T, sev_pkg::CH_R, sev_pkg::CH_ZERO,
            sev_pkg::CH_DQUOTE, sev_pkg::CH_SQUOTE, sev_pkg::CH_BACKSLASH: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    // failure is pinned to the backslash, on the line current at the time
    task automatic flag_bad;
        bad_line = cur_line;
        bad_col  = bs_col;
        scan_ph  = sev_pkg::PH_FAILED;
    endtask

    task automatic clear_scan;
        scan_ph  = sev_pkg::PH_TEXT;
        depth    = '0;
        cur_line = '0;
        cur_col  = '0;
        bs_col   = '0;
        bad_line = '0;
        bad_col  = '0;
    endtask

    task automatic scan_byte(input logic [7:0] b, input logic first, input logic last,
                             input logic [sev_pkg::FIELD_W-1:0] ln,
                             input logic [sev_pkg::FIELD_W-1:0] cl);
        t_verdict v;
        if (first) begin
            cur_line = ln;
            cur_col  = cl;
            scan_ph  = sev_pkg::PH_TEXT;
            depth    = '0;
            bs_col   = '0;
            bad_line = '0;
            bad_col  = '0;
        end
        case (scan_ph)
            sev_pkg::PH_ESCAPE: begin
                if (simple_escape(b)) begin
                    scan_ph = sev_pkg::PH_TEXT;
                end else if (b == sev_pkg::CH_LPAREN) begin
                    scan_ph = sev_pkg::PH_INTERP;
                    depth   = 16'd1;
                end else if (b == sev_pkg::CH_U) begin
                    scan_ph = sev_pkg::PH_U;
                end else begin
                    flag_bad();
                end
            end
            sev_pkg::PH_U: begin
                if (b == sev_pkg::CH_LBRACE) scan_ph = sev_pkg::PH_HEX_FIRST;
                else flag_bad();
            end
            sev_pkg::PH_HEX_FIRST: begin
                if (hex_char(b)) scan_ph = sev_pkg::PH_HEX_MORE;
                else flag_bad();
            end
            sev_pkg::PH_HEX_MORE: begin
                if (b == sev_pkg::CH_RBRACE) scan_ph = sev_pkg::PH_TEXT;
                else if (!hex_char(b)) flag_bad();
            end
            sev_pkg::PH_INTERP: begin
                if (b == sev_pkg::CH_LPAREN) begin
                    if (depth != DEPTH_TOP) depth = depth + 16'd1;
                end else if (b == sev_pkg::CH_RPAREN) begin
                    if (depth != '0) depth = depth - 16'd1;
                end
                if (depth == '0) scan_ph = sev_pkg::PH_TEXT;
            end
            sev_pkg::PH_FAILED: begin
            end
            default: begin
                scan_ph = sev_pkg::PH_TEXT;
                if (b == sev_pkg::CH_BACKSLASH) begin
                    bs_col  = cur_col;
                    scan_ph = sev_pkg::PH_ESCAPE;
                end
            end
        endcase

        if (b == sev_pkg::CH_NEWLINE) begin
            if (cur_line != POS_TOP) cur_line = cur_line + 1'b1;
            cur_col = 24'd1;
        end else if (cur_col != POS_TOP) begin
            cur_col = cur_col + 1'b1;
        end

        if (last) begin
            // an escape still open at the end of the body counts as bad
            if (scan_ph == sev_pkg::PH_ESCAPE || scan_ph == sev_pkg::PH_U ||
                scan_ph == sev_pkg::PH_HEX_FIRST || scan_ph == sev_pkg::PH_HEX_MORE)
                flag_bad();
            v.ok   = (scan_ph != sev_pkg::PH_FAILED);
            v.line = v.ok ? '0 : bad_line;
            v.col  = v.ok ? '0 : bad_col;
            verdicts_due.push_back(v);
            scan_ph  = sev_pkg::PH_TEXT;
            depth    = '0;
            bad_line = '0;
            bad_col  = '0;
        end
    endtask

    task automatic check_verdict(input logic [sev_pkg::M_DATA_W-1:0] d);
        t_verdict want;
        t_verdict got;
        got.ok   = d[sev_pkg::M_VALID_BIT];
        got.line = d[sev_pkg::M_LINE_LSB +: sev_pkg::FIELD_W];
        got.col  = d[sev_pkg::M_COL_LSB +: sev_pkg::FIELD_W];
        seen++;
        if (verdicts_due.size() == 0) begin
            errs++;
            $display("%0t: verdict with none due: expected none, actual ok=%0b line=%0h col=%0h",
                     $time, got.ok, got.line, got.col);
        end else begin
            want = verdicts_due.pop_front();
            if (got.ok !== want.ok) begin
                errs++;
                $display("%0t: escapes_valid expected %0b actual %0b", $time, want.ok, got.ok);
            end
            if (got.line !== want.line) begin
                errs++;
                $display("%0t: error_line expected %0h actual %0h", $time, want.line, got.line);
            end
            if (got.col !== want.col) begin
                errs++;
                $display("%0t: error_column expected %0h actual %0h", $time, want.col, got.col);
            end
            if (d[sev_pkg::M_DATA_W-1:sev_pkg::M_USED_W] !== '0) begin
                errs++;
                $display("%0t: tdata padding expected 0 actual %0h", $time,
                         d[sev_pkg::M_DATA_W-1:sev_pkg::M_USED_W]);
            end
        end
    endtask

    // outputs move by nonblocking assignment so the top sees registered values, race free
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_scan();
            verdicts_due.delete();
        end else begin
            if (i_s_tvalid && i_s_tready)
                scan_byte(i_s_tdata[sev_pkg::S_BYTE_LSB +: sev_pkg::BYTE_W], i_s_tuser[0],
                          i_s_tlast, i_s_tdata[sev_pkg::S_LINE_LSB +: sev_pkg::FIELD_W],
                          i_s_tdata[sev_pkg::S_COL_LSB +: sev_pkg::FIELD_W]);
            if (i_m_tvalid && i_m_tready)
                check_verdict(i_m_tdata);
        end
        o_mismatches  <= errs;
        o_outstanding <= verdicts_due.size();
        o_checked     <= seen;
    end

endmodule

>>> dv/tb_string_escape_validator.sv
// Top of the string escape validator testbench: clock, reset, byte stimulus with random
// gaps, receiver stalls and the final verdict.
// Depends on sev_pkg, string_escape_validator and escape_verdict_checker.
module tb_string_escape_validator;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_MAX    = 14;
    localparam int QUIET_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 4;
    localparam int RANDOM_BYTES = 380;
    localparam int NEST_DEEP    = 20;

    logic                         i_clk         = 1'b0;
    logic                         i_rst_n       = 1'b0;
    logic                         s_axis_tvalid = 1'b0;
    logic                         s_axis_tready;
    // [7:0] body_byte, [31:8] origin_line, [55:32] start_column
    logic [sev_pkg::S_DATA_W-1:0] s_axis_tdata  = '0;
    // [0] first_byte
    logic [0:0]                   s_axis_tuser  = '0;
    logic                         s_axis_tlast  = 1'b0;
    logic                         m_axis_tvalid;
    logic                         m_axis_tready = 1'b0;
    // [0] escapes_valid, [24:1] error_line, [48:25] error_column, [55:49] zero
    logic [sev_pkg::M_DATA_W-1:0] m_axis_tdata;

    int   mismatches;
    int   outstanding;
    int   checked;
    int   quiet       = 0;
    int   bytes_sent  = 0;
    int   bodies_sent = 0;
    logic tx_idle     = 1'b1;
    logic rx_idle     = 1'b1;

    logic [7:0] body_q[$];
    logic [7:0] simple_set[7] = '{sev_pkg::CH_N, sev_pkg::CH_T, sev_pkg::CH_R,
                                  sev_pkg::CH_ZERO, sev_pkg::CH_DQUOTE, sev_pkg::CH_SQUOTE,
                                  sev_pkg::CH_BACKSLASH};
    string      hex_set = "0123456789abcdefABCDEF";

    string_escape_validator u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    escape_verdict_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (s_axis_tvalid),
        .i_s_tready    (s_axis_tready),
        .i_s_tdata     (s_axis_tdata),
        .i_s_tuser     (s_axis_tuser),
        .i_s_tlast     (s_axis_tlast),
        .i_m_tvalid    (m_axis_tvalid),
        .i_m_tready    (m_axis_tready),
        .i_m_tdata     (m_axis_tdata),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding),
        .o_checked     (checked)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // tvalid stays high between back-to-back transfers; it only drops ahead of a gap
    task automatic put_byte(input logic [7:0] b, input logic first, input logic last,
                            input logic [23:0] ln, input logic [23:0] cl);
        int gap;
        gap = tx_idle ? $urandom_range(0, STALL_MAX) : 0;
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {cl, ln, b};
        s_axis_tuser  <= first;
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        bytes_sent++;
    endtask

    // position fields on later bytes are ignored by the block, so they carry noise
    task automatic send_body(input logic first, input logic [23:0] ln, input logic [23:0] cl);
        for (int i = 0; i < body_q.size(); i++) begin
            if (i == 0) put_byte(body_q[i], first, body_q.size() == 1, ln, cl);
            else put_byte(body_q[i], 1'b0, i == body_q.size() - 1, 24'($urandom),
                          24'($urandom));
        end
        bodies_sent++;
    endtask

    task automatic send_text(input string s, input logic first, input logic [23:0] ln,
                             input logic [23:0] cl);
        body_q.delete();
        for (int i = 0; i < s.len(); i++) body_q.push_back(s[i]);
        send_body(first, ln, cl);
    endtask

    task automatic settle_results;
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
    endtask

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        b = ($urandom_range(0, 7) == 0) ? sev_pkg::CH_NEWLINE : 8'($urandom_range(0, 255));
        if (b == sev_pkg::CH_BACKSLASH) b = sev_pkg::CH_LBRACE;
        return b;
    endfunction

    function automatic logic [7:0] hex_byte();
        return hex_set[$urandom_range(0, 21)];
    endfunction

    // mostly well-formed escapes with random content, a few broken ones
    task automatic build_random_body;
        int pick;
        int sub;
        int open;
        body_q.delete();
        repeat ($urandom_range(1, 6)) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                body_q.push_back(plain_byte());
            end else if (pick < 65) begin
                body_q.push_back(sev_pkg::CH_BACKSLASH);
                body_q.push_back(simple_set[$urandom_range(0, 6)]);
            end else if (pick < 77) begin
                body_q.push_back(sev_pkg::CH_BACKSLASH);
                body_q.push_back(sev_pkg::CH_U);
                body_q.push_back(sev_pkg::CH_LBRACE);
                repeat ($urandom_range(1, 6)) body_q.push_back(hex_byte());
                body_q.push_back(sev_pkg::CH_RBRACE);
            end else if (pick < 91) begin
                body_q.push_back(sev_pkg::CH_BACKSLASH);
                body_q.push_back(sev_pkg::CH_LPAREN);
                open = 1;
                repeat ($urandom_range(0, 6)) begin
                    sub = $urandom_range(0, 3);
                    if (sub == 0) begin
                        body_q.push_back(sev_pkg::CH_LPAREN);
                        open++;
                    end else if (sub == 1 && open > 1) begin
                        body_q.push_back(sev_pkg::CH_RPAREN);
                        open--;
                    end else if (sub == 2) begin
                        body_q.push_back(sev_pkg::CH_BACKSLASH);
                    end else begin
                        body_q.push_back(plain_byte());
                    end
                end
                // now and then the interpolation is left open
                if ($urandom_range(0, 3) != 0)
                    repeat (open) body_q.push_back(sev_pkg::CH_RPAREN);
            end else begin
                body_q.push_back(sev_pkg::CH_BACKSLASH);
                case ($urandom_range(0, 4))
                    0: body_q.push_back(8'($urandom_range(0, 255)));
                    1: begin
                        body_q.push_back(sev_pkg::CH_U);
                        body_q.push_back(8'($urandom_range(0, 255)));
                    end
                    2: begin
                        body_q.push_back(sev_pkg::CH_U);
                        body_q.push_back(sev_pkg::CH_LBRACE);
                        body_q.push_back(8'($urandom_range(0, 255)));
                    end
                    3: begin
                        body_q.push_back(sev_pkg::CH_U);
                        body_q.push_back(sev_pkg::CH_LBRACE);
                        body_q.push_back(hex_byte());
                        body_q.push_back(8'($urandom_range(0, 255)));
                    end
                    default: begin
                    end
                endcase
            end
        end
    endtask

    task automatic send_random_body;
        logic [23:0] ln;
        logic [23:0] cl;
        case ($urandom_range(0, 3))
            0: begin
                ln = 24'($urandom_range(0, 99));
                cl = 24'($urandom_range(0, 99));
            end
            1: begin
                ln = 24'hFFFFFF - 24'($urandom_range(0, 3));
                cl = 24'hFFFFFF - 24'($urandom_range(0, 12));
            end
            default: begin
                ln = 24'($urandom);
                cl = 24'($urandom);
            end
        endcase
        build_random_body();
        send_body($urandom_range(0, 19) != 0, ln, cl);
    endtask

    initial begin
        int stall;
        forever begin
            stall = rx_idle ? $urandom_range(0, STALL_MAX) : 0;
            if (stall != 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet == QUIET_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        int target;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_text("a", 1'b1, 24'h0, 24'h0);
        body_q = '{8'h00, 8'hFF};
        send_body(1'b1, 24'h000001, 24'hFFFFFF);
        send_text("\\n\\t\\r\\0\\\"\\'\\\\", 1'b1, 24'd1, 24'd1);
        send_text("\\q", 1'b1, 24'd5, 24'd9);
        send_text("ok\\\nx", 1'b1, 24'd7, 24'd3);
        send_text("\\u{aF09}\\(a(b)c)", 1'b1, 24'd12, 24'd40);
        send_text("\\(\\q)\\z", 1'b1, 24'd2, 24'd2);
        send_text("\\(x(", 1'b1, 24'd3, 24'd3);
        send_text("\\u", 1'b1, 24'd4, 24'd4);
        send_text("\\u{", 1'b1, 24'd4, 24'd4);
        send_text("\\u{7", 1'b1, 24'd4, 24'd4);
        send_text("\\u{}", 1'b1, 24'd6, 24'd6);
        send_text("\\uX", 1'b1, 24'd6, 24'd6);
        send_text("\\u{1g}", 1'b1, 24'd6, 24'd6);
        send_text("\\x\\y", 1'b1, 24'd8, 24'd8);
        // column and line held at their ceiling
        send_text("ab\\", 1'b1, 24'hFFFFFF, 24'hFFFFFE);
        send_text("\n\n\\", 1'b1, 24'hFFFFFE, 24'd3);
        // bodies without a first marker carry on from the previous position
        send_text("mn", 1'b0, 24'h0, 24'h0);
        send_text("\\v", 1'b0, 24'h0, 24'h0);
        settle_results();

        // deep nesting, unwound to one open level, so the bad escape after it goes unchecked
        tx_idle = 1'b0;
        body_q.delete();
        body_q.push_back(sev_pkg::CH_BACKSLASH);
        body_q.push_back(sev_pkg::CH_LPAREN);
        repeat (NEST_DEEP) body_q.push_back(sev_pkg::CH_LPAREN);
        repeat (NEST_DEEP) body_q.push_back(sev_pkg::CH_RPAREN);
        body_q.push_back(sev_pkg::CH_BACKSLASH);
        body_q.push_back("q");
        send_body(1'b1, 24'h000010, 24'h0);
        settle_results();

        for (int chunk = 0; chunk < 4; chunk++) begin
            tx_idle = (chunk != 1);
            rx_idle = (chunk != 2);
            target  = bytes_sent + RANDOM_BYTES / 4;
            while (bytes_sent < target) begin
                send_random_body();
                if ($urandom_range(0, 15) == 0) settle_results();
            end
            settle_results();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Run covered %0d bytes in %0d bodies, %0d verdicts checked.",
                 bytes_sent, bodies_sent, checked);
        $display("Simple, unicode and interpolation escapes, broken and unfinished escapes,");
        $display("saturated line and column, deep nesting, with and without idle cycles.");
        if (mismatches == 0 && outstanding == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
